/* src/sfod_pkg.sv */
// Shared constants, register indexes and types for the spectral flux onset detector.
// Used by sfod_frame and spectral_flux_onset_detector_core; depends on nothing.
`default_nettype none

package sfod_pkg;

   localparam int SPECTRUM_DEPTH_DEF    = 2048;
   localparam int FLUX_WINDOW_DEPTH_DEF = 64;
   localparam int MAG_BITS_DEF          = 16;

   localparam int MAG_FIELD_W  = 16;
   localparam int MAG_BITS_MAX = 24;
   localparam int TIME_W       = 32;
   localparam int FLUX_W       = 27;
   localparam int NORM_W       = 11;
   localparam int NORM_SHIFT   = 8;
   localparam int SCALE_W      = 10;
   localparam int SCALE_SHIFT  = 12;
   localparam int REFR_W       = 16;
   localparam int MINH_W       = 8;

   localparam int ROOT_W   = FLUX_W + 4;
   localparam int TERM_W   = ROOT_W + SCALE_W - SCALE_SHIFT;
   localparam int THRESH_W = TERM_W + 1;

   localparam logic [FLUX_W-1:0] FLUX_MAX = {FLUX_W{1'b1}};
   localparam logic [NORM_W-1:0] NORM_MAX = NORM_W'(1024);

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SCALE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_REFRACTORY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_MIN_HIST   = 2'd2;

   localparam logic [SCALE_W-1:0] SCALE_RESET    = SCALE_W'(384);
   localparam logic [REFR_W-1:0]  REFR_RESET     = REFR_W'(80);
   localparam logic [MINH_W-1:0]  MIN_HIST_RESET = MINH_W'(10);

   typedef struct packed {
      logic [SCALE_W-1:0] threshold_scale;
      logic [REFR_W-1:0]  refractory_ms;
      logic [MINH_W-1:0]  min_history;
   } cfg_type;

   typedef struct packed {
      logic [FLUX_W-1:0] flux;
      logic [TIME_W-1:0] time_ms;
   } frame_req_type;

   typedef struct packed {
      logic [FLUX_W-1:0] flux_raw;
      logic [NORM_W-1:0] flux_norm;
      logic              onset;
   } frame_rsp_type;

endpackage

`default_nettype wire

/* src/sfod_frame.sv */
// Per-frame statistics: flux history memory, running sums, shared divider, square root
// and the onset decision. Depends on sfod_pkg.
`default_nettype none

module sfod_frame #(
   parameter int FLUX_WINDOW_DEPTH = sfod_pkg::FLUX_WINDOW_DEPTH_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start_valid,
   input  wire sfod_pkg::frame_req_type start,
   input  wire sfod_pkg::cfg_type  cfg,
   input  wire                     res_ready,
   output logic                    busy,
   output logic                    res_valid,
   output sfod_pkg::frame_rsp_type res
);

   localparam int FluxW   = sfod_pkg::FLUX_W;
   localparam int ThW     = sfod_pkg::THRESH_W;
   localparam int RootW   = sfod_pkg::ROOT_W;
   localparam int WinW    = $clog2(FLUX_WINDOW_DEPTH);
   localparam int FillW   = $clog2(FLUX_WINDOW_DEPTH + 1);
   localparam int SumW    = FluxW + WinW;
   localparam int SqW     = 2 * FluxW + WinW;
   localparam int DivW    = SqW;
   localparam int CntW    = $clog2(DivW);
   localparam int VarW    = 2 * FluxW;
   localparam int RadW    = 2 * RootW;
   localparam int RemW    = RootW + 2;
   localparam int MulAW   = RootW;
   localparam int MulBW   = FluxW;
   localparam int ProdW   = MulAW + MulBW;
   localparam int CmpW    = (FillW > sfod_pkg::MINH_W) ? FillW : sfod_pkg::MINH_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RD_OLD   = 4'd1;
   localparam logic [3:0] ST_SUB_SQ   = 4'd2;
   localparam logic [3:0] ST_ADD_SQ   = 4'd3;
   localparam logic [3:0] ST_DIV_MEAN = 4'd4;
   localparam logic [3:0] ST_MEAN     = 4'd5;
   localparam logic [3:0] ST_DIV_MSQ  = 4'd6;
   localparam logic [3:0] ST_VAR      = 4'd7;
   localparam logic [3:0] ST_SQRT     = 4'd8;
   localparam logic [3:0] ST_MUL_TH   = 4'd9;
   localparam logic [3:0] ST_THRESH   = 4'd10;
   localparam logic [3:0] ST_NORM_LD  = 4'd11;
   localparam logic [3:0] ST_DIV_NORM = 4'd12;
   localparam logic [3:0] ST_DONE     = 4'd13;

   localparam logic [CntW-1:0] DivLast  = CntW'(DivW - 1);
   localparam logic [CntW-1:0] SqrtLast = CntW'(RootW - 1);
   localparam logic [WinW-1:0] WidxLast = WinW'(FLUX_WINDOW_DEPTH - 1);
   localparam logic [FillW-1:0] FillFull = FillW'(FLUX_WINDOW_DEPTH);

   logic [FluxW-1:0] hist_mem [FLUX_WINDOW_DEPTH];

   logic [3:0]               state_ff, state_in;
   logic [FluxW-1:0]         flux_ff;
   logic [sfod_pkg::TIME_W-1:0] time_ff;
   logic [FluxW-1:0]         old_ff;
   logic [SumW-1:0]          sum_ff;
   logic [SqW-1:0]           sumsq_ff;
   logic [WinW-1:0]          widx_ff;
   logic [FillW-1:0]         fill_ff;
   logic [ProdW-1:0]         prod_ff;
   logic [DivW-1:0]          nq_ff;
   logic [ThW-1:0]           rem_ff;
   logic [ThW-1:0]           dvs_ff;
   logic [CntW-1:0]          cnt_ff;
   logic [FluxW-1:0]         mean_ff;
   logic [RadW-1:0]          rad_ff;
   logic [RootW-1:0]         root_ff;
   logic [RemW-1:0]          srem_ff;
   logic [ThW-1:0]           thresh_ff;
   logic                     onset_ff;
   logic [sfod_pkg::TIME_W-1:0] last_onset_ff;
   logic                     seen_ff;

   logic                     full;
   logic [MulAW-1:0]         mul_a;
   logic [MulBW-1:0]         mul_b;
   logic [ThW:0]             div_sh;
   logic                     div_ge;
   logic [ThW-1:0]           div_rem_in;
   logic [RemW+1:0]          sq_sh;
   logic [RemW+1:0]          sq_trial;
   logic                     sq_ge;
   logic [RemW-1:0]          srem_in;
   logic [VarW-1:0]          msq;
   logic [VarW-1:0]          mean_sq;
   logic [VarW-1:0]          var_val;
   logic [sfod_pkg::TIME_W-1:0] elapsed;
   logic                     onset_in;

   assign full = (fill_ff == FillFull);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (start_valid) state_in = ST_RD_OLD;
         ST_RD_OLD:   state_in = ST_SUB_SQ;
         ST_SUB_SQ:   state_in = ST_ADD_SQ;
         ST_ADD_SQ:   state_in = ST_DIV_MEAN;
         ST_DIV_MEAN: if (cnt_ff == DivLast) state_in = ST_MEAN;
         ST_MEAN:     state_in = ST_DIV_MSQ;
         ST_DIV_MSQ:  if (cnt_ff == DivLast) state_in = ST_VAR;
         ST_VAR:      state_in = ST_SQRT;
         ST_SQRT:     if (cnt_ff == SqrtLast) state_in = ST_MUL_TH;
         ST_MUL_TH:   state_in = ST_THRESH;
         ST_THRESH:   state_in = ST_NORM_LD;
         ST_NORM_LD:  state_in = ST_DIV_NORM;
         ST_DIV_NORM: if (cnt_ff == DivLast) state_in = ST_DONE;
         ST_DONE:     if (res_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_RD_OLD: begin
            mul_a = MulAW'(old_ff);
            mul_b = old_ff;
         end
         ST_SUB_SQ: begin
            mul_a = MulAW'(flux_ff);
            mul_b = flux_ff;
         end
         ST_DIV_MSQ: begin
            mul_a = MulAW'(mean_ff);
            mul_b = mean_ff;
         end
         default: begin
            mul_a = root_ff;
            mul_b = MulBW'(cfg.threshold_scale);
         end
      endcase
   end

   assign div_sh     = {rem_ff, nq_ff[DivW-1]};
   assign div_ge     = (div_sh >= {1'b0, dvs_ff});
   assign div_rem_in = div_ge ? ThW'(div_sh - {1'b0, dvs_ff}) : div_sh[ThW-1:0];

   assign sq_sh    = {srem_ff, rad_ff[RadW-1 -: 2]};
   assign sq_trial = (RemW+2)'({root_ff, 2'b01});
   assign sq_ge    = (sq_sh >= sq_trial);
   assign srem_in  = sq_ge ? RemW'(sq_sh - sq_trial) : RemW'(sq_sh);

   assign msq     = nq_ff[VarW-1:0];
   assign mean_sq = prod_ff[VarW-1:0];
   assign var_val = (msq > mean_sq) ? (msq - mean_sq) : '0;

   assign elapsed  = start.time_ms - last_onset_ff;
   assign onset_in = (CmpW'(fill_ff) > CmpW'(cfg.min_history))
                     && (ThW'(flux_ff) > thresh_ff)
                     && (!seen_ff || ((time_ff - last_onset_ff)
                                      > sfod_pkg::TIME_W'(cfg.refractory_ms)));

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start_valid) begin
         old_ff <= hist_mem[widx_ff];
      end
      if (state_ff == ST_RD_OLD) begin
         hist_mem[widx_ff] <= flux_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            flux_ff <= start.flux;
            time_ff <= start.time_ms;
         end
         ST_ADD_SQ, ST_MEAN, ST_NORM_LD: begin
            rem_ff <= '0;
            cnt_ff <= '0;
            if (state_ff == ST_ADD_SQ) begin
               nq_ff  <= DivW'(sum_ff);
               dvs_ff <= ThW'(fill_ff);
            end else if (state_ff == ST_MEAN) begin
               nq_ff   <= sumsq_ff;
               mean_ff <= nq_ff[FluxW-1:0];
            end else begin
               nq_ff    <= DivW'({flux_ff, sfod_pkg::NORM_SHIFT'(0)});
               dvs_ff   <= thresh_ff;
               onset_ff <= onset_in;
            end
         end
         ST_DIV_MEAN, ST_DIV_MSQ, ST_DIV_NORM: begin
            nq_ff  <= {nq_ff[DivW-2:0], div_ge};
            rem_ff <= div_rem_in;
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_VAR: begin
            rad_ff  <= {var_val, sfod_pkg::NORM_SHIFT'(0)};
            root_ff <= '0;
            srem_ff <= '0;
            cnt_ff  <= '0;
         end
         ST_SQRT: begin
            rad_ff  <= {rad_ff[RadW-3:0], 2'b00};
            root_ff <= {root_ff[RootW-2:0], sq_ge};
            srem_ff <= srem_in;
            cnt_ff  <= cnt_ff + 1'b1;
         end
         ST_THRESH: begin
            thresh_ff <= ThW'(mean_ff)
                         + ThW'(prod_ff[sfod_pkg::SCALE_SHIFT +: sfod_pkg::TERM_W])
                         + ThW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         sumsq_ff      <= '0;
         widx_ff       <= '0;
         fill_ff       <= '0;
         last_onset_ff <= '0;
         seen_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RD_OLD && full) begin
            sum_ff <= sum_ff - SumW'(old_ff);
         end
         if (state_ff == ST_SUB_SQ) begin
            if (full) begin
               sumsq_ff <= sumsq_ff - SqW'(prod_ff);
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
            sum_ff  <= sum_ff + SumW'(flux_ff);
            widx_ff <= (widx_ff == WidxLast) ? '0 : widx_ff + 1'b1;
         end
         if (state_ff == ST_ADD_SQ) begin
            sumsq_ff <= sumsq_ff + SqW'(prod_ff);
         end
         if (state_ff == ST_NORM_LD && onset_in) begin
            seen_ff       <= 1'b1;
            last_onset_ff <= time_ff;
         end
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign res_valid     = (state_ff == ST_DONE);
   assign res.flux_raw  = flux_ff;
   assign res.flux_norm = (nq_ff > DivW'(sfod_pkg::NORM_MAX)) ? sfod_pkg::NORM_MAX
                                                              : nq_ff[sfod_pkg::NORM_W-1:0];
   assign res.onset     = onset_ff;

   // The elapsed time seen at frame start is unused; the refractory check uses time_ff.
   logic unused_elapsed;
   assign unused_elapsed = ^elapsed;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start_valid |-> state_ff == ST_IDLE)
      else $error("frame start while statistics still in progress");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillFull)
      else $error("window fill count beyond window depth");

   a_onset_above: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.onset |-> ThW'(res.flux_raw) > thresh_ff && seen_ff)
      else $error("onset reported without flux above threshold");

   a_norm_clamp: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res.flux_norm <= sfod_pkg::NORM_MAX)
      else $error("normalized flux above clamp");

endmodule

`default_nettype wire

/* src/spectral_flux_onset_detector_core.sv */
// Spectral flux onset detector top level: bin front end with previous-frame memory,
// register port and result register. Depends on sfod_pkg and sfod_frame.
// Throughput: one bin per cycle; a last bin waits while the previous frame is still in sfod_frame.
// The result is set by three passes of the bit-serial divider and the 31-step root,
// which run after the last bin has reached sfod_frame.
// Reset: synchronous; after it a sweep zeroes every entry of the previous-frame memory,
// with req_tready low; register writes are taken throughout.
`default_nettype none

module spectral_flux_onset_detector_core #(
   parameter int SPECTRUM_DEPTH    = sfod_pkg::SPECTRUM_DEPTH_DEF,
   parameter int FLUX_WINDOW_DEPTH = sfod_pkg::FLUX_WINDOW_DEPTH_DEF,
   parameter int MAG_BITS          = sfod_pkg::MAG_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // magnitude [15:0], time_ms [47:16]
   input  wire [sfod_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                               req_tlast,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // flux_raw [26:0], flux_norm [37:27], zero fill [39:38]
   output logic [sfod_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // onset [0]
   output logic                              rsp_tuser,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [sfod_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [sfod_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AddrW = $clog2(SPECTRUM_DEPTH);
   localparam int PosW  = AddrW + 1;
   localparam int FluxW = sfod_pkg::FLUX_W;
   localparam logic [PosW-1:0]  PosEnd  = PosW'(SPECTRUM_DEPTH);
   localparam logic [AddrW-1:0] AddrTop = AddrW'(SPECTRUM_DEPTH - 1);

   logic [MAG_BITS-1:0] prev_mem [SPECTRUM_DEPTH];

   sfod_pkg::cfg_type       cfg_ff;
   logic                    clr_ff;
   logic [AddrW-1:0]        clr_addr_ff;
   logic [PosW-1:0]         pos_ff;
   logic [FluxW-1:0]        acc_ff, acc_in;
   logic                    s1_valid_ff;
   logic                    s1_last_ff;
   logic                    s1_wr_ff;
   logic                    s1_interior_ff;
   logic [AddrW-1:0]        s1_addr_ff;
   logic [MAG_BITS-1:0]     s1_mag_ff;
   logic [sfod_pkg::TIME_W-1:0] s1_time_ff;
   logic [MAG_BITS-1:0]     prev_rd_ff;
   logic                    fwd_ff;
   logic [MAG_BITS-1:0]     fwd_data_ff;
   logic                    rsp_valid_ff;
   sfod_pkg::frame_rsp_type rsp_data_ff;

   logic                    req_fire;
   logic [sfod_pkg::MAG_BITS_MAX-1:0] mag_ext;
   logic [MAG_BITS-1:0]     mag;
   logic [sfod_pkg::TIME_W-1:0] time_in;
   logic                    in_range;
   logic [AddrW-1:0]        addr;
   logic [MAG_BITS-1:0]     old_mag;
   logic [FluxW:0]          acc_sum;
   logic                    frm_start_valid;
   sfod_pkg::frame_req_type frm_start;
   logic                    frm_busy;
   logic                    frm_res_valid;
   logic                    frm_res_ready;
   sfod_pkg::frame_rsp_type frm_res;

   assign mag_ext  = sfod_pkg::MAG_BITS_MAX'(req_tdata[sfod_pkg::MAG_FIELD_W-1:0]);
   assign mag      = mag_ext[MAG_BITS-1:0];
   assign time_in  = req_tdata[sfod_pkg::MAG_FIELD_W +: sfod_pkg::TIME_W];
   assign in_range = (pos_ff < PosEnd);
   assign addr     = pos_ff[AddrW-1:0];

   assign req_tready = !clr_ff && !(req_tlast && (frm_busy || (s1_valid_ff && s1_last_ff)));
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_scale <= sfod_pkg::SCALE_RESET;
         cfg_ff.refractory_ms   <= sfod_pkg::REFR_RESET;
         cfg_ff.min_history     <= sfod_pkg::MIN_HIST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sfod_pkg::CSR_IDX_SCALE:
               cfg_ff.threshold_scale <= csr_data[sfod_pkg::SCALE_W-1:0];
            sfod_pkg::CSR_IDX_REFRACTORY:
               cfg_ff.refractory_ms <= csr_data[sfod_pkg::REFR_W-1:0];
            sfod_pkg::CSR_IDX_MIN_HIST:
               cfg_ff.min_history <= csr_data[sfod_pkg::MINH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         prev_mem[clr_addr_ff] <= '0;
      end else if (s1_valid_ff && s1_wr_ff) begin
         prev_mem[s1_addr_ff] <= s1_mag_ff;
      end
      if (req_fire) begin
         prev_rd_ff <= prev_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_last_ff     <= req_tlast;
         s1_wr_ff       <= in_range;
         s1_interior_ff <= in_range && (pos_ff != '0) && !req_tlast;
         s1_addr_ff     <= addr;
         s1_mag_ff      <= mag;
         s1_time_ff     <= time_in;
         fwd_ff         <= s1_valid_ff && s1_wr_ff && (s1_addr_ff == addr);
         fwd_data_ff    <= s1_mag_ff;
      end
   end

   assign old_mag = fwd_ff ? fwd_data_ff : prev_rd_ff;
   assign acc_sum = {1'b0, acc_ff} + (FluxW+1)'(s1_mag_ff - old_mag);

   always_comb begin
      acc_in = acc_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            acc_in = '0;
         end else if (s1_interior_ff && s1_mag_ff > old_mag) begin
            acc_in = acc_sum[FluxW] ? sfod_pkg::FLUX_MAX : acc_sum[FluxW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         pos_ff      <= '0;
         acc_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AddrTop) begin
               clr_ff <= 1'b0;
            end
         end
         s1_valid_ff <= req_fire;
         acc_ff      <= acc_in;
         if (req_fire) begin
            if (req_tlast) begin
               pos_ff <= '0;
            end else if (in_range) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   assign frm_start_valid   = s1_valid_ff && s1_last_ff;
   assign frm_start.flux    = acc_ff;
   assign frm_start.time_ms = s1_time_ff;
   assign frm_res_ready     = !rsp_valid_ff || rsp_tready;

   sfod_frame #(
      .FLUX_WINDOW_DEPTH(FLUX_WINDOW_DEPTH)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .start_valid(frm_start_valid),
      .start      (frm_start),
      .cfg        (cfg_ff),
      .res_ready  (frm_res_ready),
      .busy       (frm_busy),
      .res_valid  (frm_res_valid),
      .res        (frm_res)
   );

   always_ff @(posedge clock) begin
      if (frm_res_valid && frm_res_ready) begin
         rsp_data_ff <= frm_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frm_res_valid && frm_res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sfod_pkg::RSP_DATA_W'({rsp_data_ff.flux_norm, rsp_data_ff.flux_raw});
   assign rsp_tuser  = rsp_data_ff.onset;

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |-> !frm_busy)
      else $error("frame end reached the statistics unit while it was busy");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosEnd)
      else $error("bin position beyond spectrum depth");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_ff) |-> $past(clr_addr_ff) == AddrTop)
      else $error("clearing sweep ended before the last entry");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      frm_start_valid |=> acc_ff == '0 || (s1_valid_ff && s1_interior_ff))
      else $error("flux accumulator not cleared at frame end");

endmodule

`default_nettype wire

/* verif/tb_spectral_flux_onset_detector_core.sv */
// Self-checking testbench for spectral_flux_onset_detector_core: streams magnitude bins,
// predicts each frame's flux, normalized flux and onset flag, and checks every result word.
// Depends on sfod_pkg and the core RTL; needs no files or arguments.
module tb_spectral_flux_onset_detector_core;
   import sfod_pkg::*;

   localparam int SPEC_DEPTH = SPECTRUM_DEPTH_DEF;
   localparam int WIN_DEPTH = FLUX_WINDOW_DEPTH_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 260;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 175;
   localparam int NUM_PHASES = 4;
   localparam int DIR_ROWS = 23;

   typedef enum int {LEVEL_QUIET, LEVEL_LOUD, LEVEL_FULL} frame_level_type;

   typedef struct packed {
      logic [MAG_FIELD_W-1:0] mag;
      logic                   last;
      logic [TIME_W-1:0]      now_ms;
      logic                   typed;
      logic [FLUX_W-1:0]      flux;
      logic [NORM_W-1:0]      norm;
      logic                   onset;
   } bin_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [SCALE_W-1:0] cfg_scale = SCALE_RESET;
   logic [REFR_W-1:0] cfg_refr = REFR_RESET;
   logic [MINH_W-1:0] cfg_min_hist = MIN_HIST_RESET;

   logic [MAG_FIELD_W-1:0] prev_mag [SPEC_DEPTH];
   longint unsigned flux_acc = 0;
   int unsigned bin_pos = 0;
   longint unsigned flux_win [WIN_DEPTH];
   longint unsigned win_sum = 0;
   longint unsigned win_sumsq = 0;
   int unsigned win_wr = 0;
   int unsigned win_fill = 0;
   logic [TIME_W-1:0] last_onset_ms = '0;
   logic onset_armed = 1'b0;

   frame_rsp_type pending_results [$];
   frame_rsp_type want_rsp;
   bin_step_type directed_steps [DIR_ROWS];
   int mismatch_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int send_gap_max = 4;
   int rsp_stall_max = 4;

   spectral_flux_onset_detector_core uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("spectral_flux_onset_detector_core test failed");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      longint unsigned rem;
      rem = v;
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic predict_frame_result(input logic [MAG_FIELD_W-1:0] mag,
                                                 input logic last,
                                                 input logic [TIME_W-1:0] now_ms,
                                                 output frame_rsp_type rsp);
      int unsigned pos;
      longint unsigned flux, n, mean, msq, var_q, sd16, thresh, norm, oldf, scale;
      logic [TIME_W-1:0] elapsed;
      logic onset;
      pos = bin_pos;
      rsp = '0;
      if (pos < SPEC_DEPTH) begin
         if (pos != 0 && !last && mag > prev_mag[pos]) begin
            flux_acc = flux_acc + (mag - prev_mag[pos]);
            if (flux_acc > FLUX_MAX) flux_acc = FLUX_MAX;
         end
         prev_mag[pos] = mag;
      end
      if (!last) begin
         if (pos < SPEC_DEPTH) bin_pos = pos + 1;
         return 1'b0;
      end
      flux = flux_acc;
      flux_acc = 0;
      bin_pos = 0;
      if (win_fill >= WIN_DEPTH) begin
         oldf = flux_win[win_wr];
         win_sum = win_sum - oldf;
         win_sumsq = win_sumsq - oldf * oldf;
      end else begin
         win_fill = win_fill + 1;
      end
      flux_win[win_wr] = flux;
      win_sum = win_sum + flux;
      win_sumsq = win_sumsq + flux * flux;
      win_wr = (win_wr + 1) % WIN_DEPTH;
      n = win_fill;
      mean = win_sum / n;
      msq = win_sumsq / n;
      var_q = (msq > mean * mean) ? msq - mean * mean : 0;
      sd16 = int_sqrt(var_q << 8);
      scale = cfg_scale;
      thresh = mean + ((scale * sd16) >> SCALE_SHIFT) + 1;
      norm = (flux << NORM_SHIFT) / thresh;
      if (norm > NORM_MAX) norm = NORM_MAX;
      onset = 1'b0;
      if (win_fill > cfg_min_hist && flux > thresh) begin
         elapsed = now_ms - last_onset_ms;
         if (!onset_armed || elapsed > cfg_refr) begin
            onset = 1'b1;
            onset_armed = 1'b1;
            last_onset_ms = now_ms;
         end
      end
      rsp.flux_raw = flux[FLUX_W-1:0];
      rsp.flux_norm = norm[NORM_W-1:0];
      rsp.onset = onset;
      return 1'b1;
   endfunction

   task automatic send_bin(input logic [MAG_FIELD_W-1:0] mag, input logic last,
                           input logic [TIME_W-1:0] now_ms, input logic typed,
                           input frame_rsp_type typed_rsp);
      int gap;
      frame_rsp_type rsp;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {now_ms, mag};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (predict_frame_result(mag, last, now_ms, rsp))
         pending_results.push_back(typed ? typed_rsp : rsp);
   endtask

   task automatic send_frame(input int len, input frame_level_type level,
                             input logic [TIME_W-1:0] now_ms);
      int ceiling;
      int i;
      logic [MAG_FIELD_W-1:0] mag;
      ceiling = $urandom_range(0, 3000);
      for (i = 0; i < len; i++) begin
         case (level)
            LEVEL_FULL: mag = '1;
            LEVEL_LOUD: mag = MAG_FIELD_W'($urandom);
            default:    mag = MAG_FIELD_W'($urandom_range(0, ceiling));
         endcase
         send_bin(mag, i == len - 1, (i == len - 1) ? now_ms : TIME_W'($urandom), 1'b0, '0);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_IDX_SCALE:      cfg_scale = value[SCALE_W-1:0];
         CSR_IDX_REFRACTORY: cfg_refr = value;
         CSR_IDX_MIN_HIST:   cfg_min_hist = value[MINH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [SCALE_W-1:0] scale, input logic [REFR_W-1:0] refr,
                            input logic [MINH_W-1:0] min_hist);
      write_reg(CSR_IDX_UNUSED, CSR_DATA_W'($urandom));
      write_reg(CSR_IDX_SCALE, CSR_DATA_W'(scale));
      write_reg(CSR_IDX_REFRACTORY, refr);
      write_reg(CSR_IDX_MIN_HIST, CSR_DATA_W'(min_hist));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: when stalls are on, a stall is drawn once a word is waiting.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_stall_max == 0) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
            stall = $urandom_range(0, rsp_stall_max);
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
         end
         if ($urandom_range(0, 15) == 0) rsp_stall_max = (rsp_stall_max == 0) ? 4 : 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: flux_raw %0d", rsp_tdata[FLUX_W-1:0]);
            mismatch_count++;
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_tdata[FLUX_W-1:0] !== want_rsp.flux_raw) begin
               $error("flux_raw: expected %0d, got %0d", want_rsp.flux_raw,
                      rsp_tdata[FLUX_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[FLUX_W+NORM_W-1:FLUX_W] !== want_rsp.flux_norm) begin
               $error("flux_norm: expected %0d, got %0d", want_rsp.flux_norm,
                      rsp_tdata[FLUX_W+NORM_W-1:FLUX_W]);
               mismatch_count++;
            end
            if (rsp_tuser !== want_rsp.onset) begin
               $error("onset: expected %0d, got %0d", want_rsp.onset, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int k;
      int phase;
      int phase_start;
      int len;
      int pick;
      frame_level_type level;
      logic [TIME_W-1:0] frame_ms;
      frame_rsp_type typed_rsp;

      for (k = 0; k < SPEC_DEPTH; k++) prev_mag[k] = '0;
      for (k = 0; k < WIN_DEPTH; k++) flux_win[k] = 0;

      // Single-bin frame, full-scale rise, decays, a refractory block across the
      // timestamp wrap, then a rise late enough to fire again.
      directed_steps = '{
         {16'h0000, 1'b1, 32'h0000_0000, 1'b1, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b0, 32'hFFFF_FFFF, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b1, 32'h0000_0030, 1'b1, 27'd0, 11'd0, 1'b0},
         {16'h0005, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b1, 32'h0000_0040, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b1, 32'h0000_0080, 1'b1, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 27'd0, 11'd0, 1'b0},
         {16'h0000, 1'b1, 32'h0000_0100, 1'b0, 27'd0, 11'd0, 1'b0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      configure('0, REFR_RESET, '0);

      for (k = 0; k < DIR_ROWS; k++) begin
         typed_rsp.flux_raw = directed_steps[k].flux;
         typed_rsp.flux_norm = directed_steps[k].norm;
         typed_rsp.onset = directed_steps[k].onset;
         send_bin(directed_steps[k].mag, directed_steps[k].last, directed_steps[k].now_ms,
                  directed_steps[k].typed, typed_rsp);
      end

      frame_ms = 32'h0000_0200;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (phase)
            0: configure('1, '0, '0);
            1: configure(SCALE_RESET, REFR_RESET, MIN_HIST_RESET);
            2: configure('0, '1, '1);
            default: configure(SCALE_W'($urandom_range(0, 1023)),
                               REFR_W'($urandom_range(0, 200)),
                               MINH_W'($urandom_range(0, 20)));
         endcase
         if (phase == 1) begin
            send_gap_max = 0;
            frame_ms = frame_ms + 40;
            send_frame(SPEC_DEPTH, LEVEL_FULL, frame_ms);
            frame_ms = frame_ms + 40;
            send_frame(SPEC_DEPTH + 52, LEVEL_LOUD, frame_ms);
            send_gap_max = 4;
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 7) == 0) send_gap_max = (send_gap_max == 0) ? 4 : 0;
            if ($urandom_range(0, 24) == 0) wait_drained();
            if ($urandom_range(0, 24) == 0)
               frame_ms = TIME_W'($urandom);
            else
               frame_ms = frame_ms + $urandom_range(0, 60);
            pick = $urandom_range(0, 9);
            if (pick == 0)
               len = 1;
            else if (pick < 3)
               len = $urandom_range(13, 64);
            else
               len = $urandom_range(2, 12);
            level = ($urandom_range(0, 5) == 0) ? LEVEL_LOUD : LEVEL_QUIET;
            send_frame(len, level, frame_ms);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("spectral_flux_onset_detector_core test passed");
      else
         $display("spectral_flux_onset_detector_core test failed");
      $finish;
   end

endmodule

/* sim.f */
src/sfod_pkg.sv
src/sfod_frame.sv
src/spectral_flux_onset_detector_core.sv
verif/tb_spectral_flux_onset_detector_core.sv
